// ----- rtl/dnap_pkg.sv -----
// Shared types, constants and the control store for the damped nested allpass delay.
package dnap_pkg;

  // Default sizes of the two delay lines and the sample word
  localparam int unsigned OuterDepthDef = 4096;
  localparam int unsigned InnerDepthDef = 1024;
  localparam int unsigned SampleBitsDef = 24;

  // Fixed register widths
  localparam int unsigned GainW = 16;
  localparam int unsigned OdlyW = 12;
  localparam int unsigned IdlyW = 10;
  localparam int unsigned CoefW = GainW + 2;  // holds -(-1.0) and 1.0 - a
  localparam int unsigned PcW   = 4;

  // Register reset values
  localparam logic                    NestedRst = 1'b0;
  localparam logic signed [GainW-1:0] OgainRst  = 16'sd16384;
  localparam logic        [GainW-1:0] DgainRst  = 16'd0;
  localparam logic        [OdlyW-1:0] OdlyRst   = 12'd1;
  localparam logic signed [GainW-1:0] IgainRst  = 16'sd16384;
  localparam logic        [IdlyW-1:0] IdlyRst   = 10'd1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RG_NESTED = 3'd0,
    RG_OGAIN  = 3'd1,
    RG_DGAIN  = 3'd2,
    RG_ODLY   = 3'd3,
    RG_IGAIN  = 3'd4,
    RG_IDLY   = 3'd5
  } reg_idx_e;

  // Multiplier coefficient operand
  typedef enum logic [2:0] {
    CF_G      = 3'd0,
    CF_NEG_G  = 3'd1,
    CF_ONE_MA = 3'd2,
    CF_A      = 3'd3,
    CF_GN     = 3'd4,
    CF_NEG_GN = 3'd5
  } coef_sel_e;

  // Multiplier sample operand
  typedef enum logic [2:0] {
    SS_D  = 3'd0,
    SS_W  = 3'd1,
    SS_M  = 3'd2,
    SS_DN = 3'd3,
    SS_T  = 3'd4
  } samp_sel_e;

  // Adder addend
  typedef enum logic [2:0] {
    AD_ZERO = 3'd0,
    AD_X    = 3'd1,
    AD_D    = 3'd2,
    AD_DN   = 3'd3,
    AD_M    = 3'd4,
    AD_ACC  = 3'd5
  } add_sel_e;

  // Adder destination
  typedef enum logic [2:0] {
    DS_NONE = 3'd0,
    DS_W    = 3'd1,
    DS_Y    = 3'd2,
    DS_ACC  = 3'd3,
    DS_M    = 3'd4,
    DS_T    = 3'd5
  } dest_e;

  // Outer line write data
  typedef enum logic {
    WS_SUM = 1'b0,
    WS_M   = 1'b1
  } wsel_e;

  // One control word
  typedef struct packed {
    logic            rd_issue;  // read both lines at the delayed positions
    logic            load_d;    // latch the line samples
    logic            prod_en;   // load the product register
    coef_sel_e       coef;
    samp_sel_e       samp;
    add_sel_e        add;
    logic            sh16;      // product scale Q.16 instead of Q.15
    dest_e           dest;
    logic            wr_inner;
    logic            wr_outer;
    wsel_e           wsel;
    logic            br_nested; // jump to target when nested mode is on
    logic [PcW-1:0]  target;
    logic            last;      // final step, result goes out
  } uop_t;

  // Control store
  function automatic uop_t uop_rom(input logic [PcW-1:0] pc);
    uop_t u;
    u = '0;
    case (pc)
      4'd0: u.rd_issue = 1'b1;
      4'd1: begin
        u.load_d  = 1'b1;
        u.prod_en = 1'b1;
        u.coef    = CF_G;
        u.samp    = SS_D;
      end
      4'd2: begin
        u.add  = AD_X;
        u.dest = DS_W;
      end
      4'd3: begin
        u.prod_en = 1'b1;
        u.coef    = CF_NEG_G;
        u.samp    = SS_W;
      end
      4'd4: begin
        u.add     = AD_D;
        u.dest    = DS_Y;
        u.prod_en = 1'b1;
        u.coef    = CF_ONE_MA;
        u.samp    = SS_W;
      end
      4'd5: begin
        u.add     = AD_ZERO;
        u.sh16    = 1'b1;
        u.dest    = DS_ACC;
        u.prod_en = 1'b1;
        u.coef    = CF_A;
        u.samp    = SS_M;
      end
      4'd6: begin
        u.add       = AD_ACC;
        u.sh16      = 1'b1;
        u.dest      = DS_M;
        u.br_nested = 1'b1;
        u.target    = 4'd8;
      end
      4'd7: begin
        u.wr_outer = 1'b1;
        u.wsel     = WS_M;
        u.last     = 1'b1;
      end
      4'd8: begin
        u.prod_en = 1'b1;
        u.coef    = CF_GN;
        u.samp    = SS_DN;
      end
      4'd9: begin
        u.add      = AD_M;
        u.dest     = DS_T;
        u.wr_inner = 1'b1;
      end
      4'd10: begin
        u.prod_en = 1'b1;
        u.coef    = CF_NEG_GN;
        u.samp    = SS_T;
      end
      4'd11: begin
        u.add      = AD_DN;
        u.wr_outer = 1'b1;
        u.wsel     = WS_SUM;
        u.last     = 1'b1;
      end
      default: u.last = 1'b1;
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/dnap_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dnap_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dnap_dmod.sv -----
// Reduces a delay setting modulo the line depth by a reciprocal multiply, quotient first.
module dnap_dmod #(
  parameter int unsigned Dw     = 12,
  parameter int unsigned Depth  = 4096,
  parameter logic [Dw-1:0] RstVal = Dw'(1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [Dw-1:0] delay_i,
  output logic          busy_o,
  output logic [Dw-1:0] mod_o
);

  localparam int unsigned Lw = $clog2(Depth);
  localparam int unsigned Sh = Dw + Lw;
  localparam int unsigned Mw = Dw + 2;
  localparam int unsigned Pw = Dw + Mw;
  localparam int unsigned Cw = Dw + Lw;
  // ceil(2^Sh / Depth): exact quotient for every Dw-bit delay
  localparam logic [63:0]   RecipL = ((64'd1 << Sh) + 64'(Depth) - 64'd1) / 64'(Depth);
  localparam logic [Mw-1:0] Recip  = Mw'(RecipL);
  localparam logic [Cw-1:0] DepthC = Cw'(Depth);

  logic [Dw-1:0] dly_q, q_q, r_q;
  logic [Dw-1:0] q_d, r_d;
  logic [Pw-1:0] qprod;
  logic [Cw-1:0] back;
  logic          busy_q;

  // quotient by reciprocal multiply
  always_comb begin
    qprod = Pw'(delay_i) * Pw'(Recip);
    q_d   = Dw'(qprod >> Sh);
  end

  // remainder: delay less quotient times depth
  always_comb begin
    back = Cw'(q_q) * DepthC;
    r_d  = dly_q - Dw'(back);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= RstVal;
      dly_q  <= '0;
      q_q    <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      dly_q  <= delay_i;
      q_q    <= q_d;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      r_q    <= r_d;
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign mod_o  = r_q;

endmodule

// ----- rtl/dnap_datapath.sv -----
// Shared multiplier, rounding adder with saturation and the working registers.
module dnap_datapath
  import dnap_pkg::*;
#(
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  uop_t                          uop_i,
  input  logic                          en_i,
  input  logic                          load_x_i,
  input  logic signed [SampleBits-1:0]  x_i,
  input  logic signed [SampleBits-1:0]  outer_d_i,
  input  logic signed [SampleBits-1:0]  inner_d_i,
  input  logic signed [GainW-1:0]       outer_gain_i,
  input  logic        [GainW-1:0]       damping_gain_i,
  input  logic signed [GainW-1:0]       inner_gain_i,
  output logic signed [SampleBits-1:0]  y_o,
  output logic signed [SampleBits-1:0]  outer_wdata_o,
  output logic signed [SampleBits-1:0]  inner_wdata_o
);

  localparam int unsigned Pw = CoefW + SampleBits;
  localparam int unsigned Sw = Pw + 2;
  localparam int unsigned Aw = SampleBits + 2;
  localparam logic signed [Sw-1:0] SatMax = (Sw'(1) <<< (SampleBits - 1)) - Sw'(1);
  localparam logic signed [Sw-1:0] SatMin = -SatMax - Sw'(1);
  localparam logic signed [Sw-1:0] Half15 = Sw'(1) <<< 14;
  localparam logic signed [Sw-1:0] Half16 = Sw'(1) <<< 15;

  logic signed [SampleBits-1:0] x_q, d_q, dn_q, w_q, y_q, m_q, t_q;
  logic signed [Aw-1:0]         acc_q;
  logic signed [Pw-1:0]         prod_q;

  logic signed [CoefW-1:0]      coef;
  logic signed [SampleBits-1:0] samp;
  logic signed [Pw-1:0]         prod_d;
  logic signed [Sw-1:0]         pwide, rnd, addend, sum;
  logic signed [SampleBits-1:0] sum_sat;

  // coefficient operand
  always_comb begin
    case (uop_i.coef)
      CF_G:      coef = CoefW'(outer_gain_i);
      CF_NEG_G:  coef = -CoefW'(outer_gain_i);
      CF_ONE_MA: coef = (CoefW'(1) <<< GainW) - $signed({2'b00, damping_gain_i});
      CF_A:      coef = $signed({2'b00, damping_gain_i});
      CF_GN:     coef = CoefW'(inner_gain_i);
      CF_NEG_GN: coef = -CoefW'(inner_gain_i);
      default:   coef = '0;
    endcase
  end

  // sample operand
  always_comb begin
    case (uop_i.samp)
      SS_D:    samp = outer_d_i;
      SS_W:    samp = w_q;
      SS_M:    samp = m_q;
      SS_DN:   samp = dn_q;
      SS_T:    samp = t_q;
      default: samp = '0;
    endcase
  end

  assign prod_d = coef * samp;

  // round half up, then scale
  always_comb begin
    pwide = Sw'(prod_q);
    if (uop_i.sh16) begin
      rnd = (pwide + Half16) >>> 16;
    end else begin
      rnd = (pwide + Half15) >>> 15;
    end
  end

  // addend
  always_comb begin
    case (uop_i.add)
      AD_ZERO: addend = '0;
      AD_X:    addend = Sw'(x_q);
      AD_D:    addend = Sw'(d_q);
      AD_DN:   addend = Sw'(dn_q);
      AD_M:    addend = Sw'(m_q);
      AD_ACC:  addend = Sw'(acc_q);
      default: addend = '0;
    endcase
  end

  // sum and clamp to the sample range
  always_comb begin
    sum = addend + rnd;
    if (sum > SatMax) begin
      sum_sat = SampleBits'(SatMax);
    end else if (sum < SatMin) begin
      sum_sat = SampleBits'(SatMin);
    end else begin
      sum_sat = SampleBits'(sum);
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (load_x_i) begin
      x_q <= x_i;
    end
    if (en_i) begin
      if (uop_i.load_d) begin
        d_q  <= outer_d_i;
        dn_q <= inner_d_i;
      end
      if (uop_i.prod_en) begin
        prod_q <= prod_d;
      end
      case (uop_i.dest)
        DS_W:    w_q   <= sum_sat;
        DS_Y:    y_q   <= sum_sat;
        DS_ACC:  acc_q <= Aw'(sum);
        DS_T:    t_q   <= sum_sat;
        default: ;
      endcase
    end
  end

  // low-pass memory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= '0;
    end else if (en_i && (uop_i.dest == DS_M)) begin
      m_q <= sum_sat;
    end
  end

  assign y_o           = y_q;
  assign outer_wdata_o = (uop_i.wsel == WS_M) ? m_q : sum_sat;
  assign inner_wdata_o = sum_sat;

endmodule

// ----- rtl/damped_nested_allpass_delay.sv -----
// Top level: step sequencer, delay lines, pointers and configuration registers.
// Each item runs the control-store steps, with at most one multiply per step; nested
// mode adds the inner allpass steps, and a new item waits for the last step to finish.
// After a delay register write, input stalls
// while the delay is reduced modulo the line depth.
// Reset clears pointers, fill flags, low-pass memory and registers; no clearing pass.
module damped_nested_allpass_delay
  import dnap_pkg::*;
#(
  parameter int unsigned OUTER_DEPTH = OuterDepthDef,
  parameter int unsigned INNER_DEPTH = InnerDepthDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned OAw = $clog2(OUTER_DEPTH);
  localparam int unsigned IAw = $clog2(INNER_DEPTH);
  localparam int unsigned OIw = ((OAw > OdlyW) ? OAw : OdlyW) + 1;
  localparam int unsigned IIw = ((IAw > IdlyW) ? IAw : IdlyW) + 1;

  // configuration registers
  logic                    nested_q;
  logic signed [GainW-1:0] ogain_q, igain_q;
  logic        [GainW-1:0] dgain_q;
  logic        [OdlyW-1:0] odly_q, odmod;
  logic        [IdlyW-1:0] idly_q, idmod;
  logic                    cfg_wr;
  reg_idx_e                cfg_idx;
  logic                    odmod_busy, idmod_busy;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nested_q <= NestedRst;
      ogain_q  <= OgainRst;
      dgain_q  <= DgainRst;
      odly_q   <= OdlyRst;
      igain_q  <= IgainRst;
      idly_q   <= IdlyRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RG_NESTED: nested_q <= pwdata[0];
        RG_OGAIN:  ogain_q  <= pwdata[GainW-1:0];
        RG_DGAIN:  dgain_q  <= pwdata[GainW-1:0];
        RG_ODLY:   odly_q   <= pwdata[OdlyW-1:0];
        RG_IGAIN:  igain_q  <= pwdata[GainW-1:0];
        RG_IDLY:   idly_q   <= pwdata[IdlyW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      RG_NESTED: prdata = {31'd0, nested_q};
      RG_OGAIN:  prdata = 32'(ogain_q);
      RG_DGAIN:  prdata = {16'd0, dgain_q};
      RG_ODLY:   prdata = {20'd0, odly_q};
      RG_IGAIN:  prdata = 32'(igain_q);
      RG_IDLY:   prdata = {22'd0, idly_q};
      default:   prdata = '0;
    endcase
  end

  // delay settings reduced modulo the line depths
  dnap_dmod #(
    .Dw     (OdlyW),
    .Depth  (OUTER_DEPTH),
    .RstVal (OdlyRst)
  ) u_odmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_wr && (cfg_idx == RG_ODLY)),
    .delay_i (pwdata[OdlyW-1:0]),
    .busy_o  (odmod_busy),
    .mod_o   (odmod)
  );

  dnap_dmod #(
    .Dw     (IdlyW),
    .Depth  (INNER_DEPTH),
    .RstVal (IdlyRst)
  ) u_idmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_wr && (cfg_idx == RG_IDLY)),
    .delay_i (pwdata[IdlyW-1:0]),
    .busy_o  (idmod_busy),
    .mod_o   (idmod)
  );

  // sequencer
  logic           busy_q;
  logic [PcW-1:0] pc_q;
  logic           out_valid_q;
  logic           stall, go, accept, finish;
  uop_t           uop;

  assign uop        = uop_rom(pc_q);
  assign stall      = uop.last && out_valid_q && !out_ready_i;
  assign go         = busy_q && !stall;
  assign finish     = go && uop.last;
  assign in_ready_o = (!busy_q || finish) && !odmod_busy && !idmod_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      pc_q   <= '0;
    end else if (finish) begin
      busy_q <= 1'b0;
    end else if (go) begin
      if (uop.br_nested && nested_q) begin
        pc_q <= uop.target;
      end else begin
        pc_q <= pc_q + 1'b1;
      end
    end
  end

  // read positions: write pointer minus reduced delay, wrapped
  logic [OAw-1:0] owp_q, o_ridx;
  logic [IAw-1:0] iwp_q, i_ridx;
  logic [OIw-1:0] o_diff;
  logic [IIw-1:0] i_diff;
  logic           owrap_q, iwrap_q, ovld_q, ivld_q;

  always_comb begin
    o_diff = OIw'(owp_q) - OIw'(odmod);
    if (o_diff[OIw-1]) begin
      o_diff = o_diff + OIw'(OUTER_DEPTH);
    end
    o_ridx = o_diff[OAw-1:0];
    i_diff = IIw'(iwp_q) - IIw'(idmod);
    if (i_diff[IIw-1]) begin
      i_diff = i_diff + IIw'(INNER_DEPTH);
    end
    i_ridx = i_diff[IAw-1:0];
  end

  // write pointers and fill tracking: an entry below the pointer, or any
  // entry once the pointer has wrapped, holds written data
  logic o_we, i_we;
  assign o_we = go && uop.wr_outer;
  assign i_we = go && uop.wr_inner;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q   <= '0;
      iwp_q   <= '0;
      owrap_q <= 1'b0;
      iwrap_q <= 1'b0;
      ovld_q  <= 1'b0;
      ivld_q  <= 1'b0;
    end else begin
      if (go && uop.rd_issue) begin
        ovld_q <= owrap_q || (o_ridx < owp_q);
        ivld_q <= iwrap_q || (i_ridx < iwp_q);
      end
      if (o_we) begin
        if (owp_q == OAw'(OUTER_DEPTH - 1)) begin
          owp_q   <= '0;
          owrap_q <= 1'b1;
        end else begin
          owp_q <= owp_q + 1'b1;
        end
      end
      if (i_we) begin
        if (iwp_q == IAw'(INNER_DEPTH - 1)) begin
          iwp_q   <= '0;
          iwrap_q <= 1'b1;
        end else begin
          iwp_q <= iwp_q + 1'b1;
        end
      end
    end
  end

  // delay lines
  logic signed [SAMPLE_BITS-1:0] o_rdata, i_rdata, o_wdata, i_wdata, o_d, i_d, y;

  dnap_ram #(
    .Width (SAMPLE_BITS),
    .Depth (OUTER_DEPTH)
  ) u_outer_ram (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (owp_q),
    .wdata_i (o_wdata),
    .re_i    (go && uop.rd_issue),
    .raddr_i (o_ridx),
    .rdata_o (o_rdata)
  );

  dnap_ram #(
    .Width (SAMPLE_BITS),
    .Depth (INNER_DEPTH)
  ) u_inner_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (iwp_q),
    .wdata_i (i_wdata),
    .re_i    (go && uop.rd_issue),
    .raddr_i (i_ridx),
    .rdata_o (i_rdata)
  );

  // entries never written read as zero
  assign o_d = ovld_q ? o_rdata : '0;
  assign i_d = ivld_q ? i_rdata : '0;

  dnap_datapath #(
    .SampleBits (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .uop_i          (uop),
    .en_i           (go),
    .load_x_i       (accept),
    .x_i            (sample_in_i),
    .outer_d_i      (o_d),
    .inner_d_i      (i_d),
    .outer_gain_i   (ogain_q),
    .damping_gain_i (dgain_q),
    .inner_gain_i   (igain_q),
    .y_o            (y),
    .outer_wdata_o  (o_wdata),
    .inner_wdata_o  (i_wdata)
  );

  // output register
  logic signed [SAMPLE_BITS-1:0] sample_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      sample_out_q <= y;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

endmodule

// ----- verif/dnap_checker.sv -----
`timescale 1ns / 100ps
// Checker for the damped nested allpass delay: tracks registers, predicts and compares samples.
module dnap_checker
  import dnap_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [23:0] sample_in_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [23:0] sample_out_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [4:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam longint SampleMax = 64'sd8388607;
  localparam longint SampleMin = -64'sd8388608;
  localparam int     ShownMax  = 10;

  // Predicted block state
  logic signed [23:0] echo_mem [OuterDepthDef];
  logic signed [23:0] nest_mem [InnerDepthDef];
  logic [OdlyW-1:0]   echo_wp;
  logic [IdlyW-1:0]   nest_wp;
  logic signed [23:0] lp_mem;

  // Register copies
  logic                    nest_on;
  logic signed [GainW-1:0] og;
  logic        [GainW-1:0] damp;
  logic        [OdlyW-1:0] odly;
  logic signed [GainW-1:0] ig;
  logic        [IdlyW-1:0] idly;

  // Predicted output samples, oldest first
  logic signed [23:0] due_samples [$];
  int mismatches;

  // Product rounded half up, then floor shift
  function automatic longint rnd_mul(input longint a, input longint b, input int sh);
    return (a * b + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > SampleMax) return SampleMax;
    if (v < SampleMin) return SampleMin;
    return v;
  endfunction

  // One sample through the outer loop, the damping filter and the optional inner allpass
  function automatic logic signed [23:0] allpass_step(input logic signed [23:0] x);
    logic [OdlyW-1:0] rd_o;
    logic [IdlyW-1:0] rd_i;
    longint d, dn, w, y, m, t, feed;
    rd_o = echo_wp - odly;
    d    = echo_mem[rd_o];
    w    = clamp24(longint'(x) + rnd_mul(og, d, 15));
    y    = clamp24(d + rnd_mul(-longint'(og), w, 15));
    m    = clamp24(rnd_mul(64'sd65536 - longint'(damp), w, 16) +
                   rnd_mul(longint'(damp), lp_mem, 16));
    lp_mem = m[23:0];
    feed   = m;
    if (nest_on) begin
      rd_i = nest_wp - idly;
      dn   = nest_mem[rd_i];
      t    = clamp24(m + rnd_mul(ig, dn, 15));
      nest_mem[nest_wp] = t[23:0];
      feed    = clamp24(dn + rnd_mul(-longint'(ig), t, 15));
      nest_wp = nest_wp + 1'b1;
    end
    echo_mem[echo_wp] = feed[23:0];
    echo_wp = echo_wp + 1'b1;
    return y[23:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [23:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < OuterDepthDef; i++) echo_mem[i] = '0;
      for (int i = 0; i < InnerDepthDef; i++) nest_mem[i] = '0;
      echo_wp      = '0;
      nest_wp      = '0;
      lp_mem       = '0;
      nest_on      = NestedRst;
      og           = OgainRst;
      damp         = DgainRst;
      odly         = OdlyRst;
      ig           = IgainRst;
      idly         = IdlyRst;
      due_samples.delete();
      mismatches   = 0;
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      // Register writes; unmapped indexes are dropped
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          RG_NESTED: nest_on = pwdata_i[0];
          RG_OGAIN:  og      = pwdata_i[GainW-1:0];
          RG_DGAIN:  damp    = pwdata_i[GainW-1:0];
          RG_ODLY:   odly    = pwdata_i[OdlyW-1:0];
          RG_IGAIN:  ig      = pwdata_i[GainW-1:0];
          RG_IDLY:   idly    = pwdata_i[IdlyW-1:0];
          default: ;
        endcase
      end

      // Output items against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (due_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownMax)
            $display("%0t: unexpected output item, sample_out %0d", $time, sample_out_i);
        end else begin
          want = due_samples.pop_front();
          if (sample_out_i !== want) begin
            mismatches++;
            if (mismatches <= ShownMax)
              $display("%0t: sample_out expected %0d, got %0d", $time, want, sample_out_i);
          end
        end
      end

      // Input items
      if (in_valid_i && in_ready_i) due_samples.push_back(allpass_step(sample_in_i));

      pending_o    = due_samples.size();
      fail_count_o = mismatches;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, sample and register stimulus, verdict.
module tb_top;
  import dnap_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int SettleCyc  = 16;
  localparam logic [2:0] UnmappedIdx = 3'd7;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic signed [23:0] sample_in_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic signed [23:0] sample_out_o;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [4:0]         paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;

  int pending;
  int fail_count;
  int cycles = 0;
  bit steady = 1'b0;  // no idling on either side while set

  damped_nested_allpass_delay i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  dnap_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_i (sample_out_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output backpressure: mostly short stalls, a few long ones
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0)
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 4);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [23:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    if (r < 4) return 24'(int'($urandom_range(0, 2000)) - 1000);
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_delay(input logic [15:0] top);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return top;
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  // Enter and leave at a falling edge; valid stays high after acceptance
  task automatic push_sample(input logic signed [23:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drain all outstanding items, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // APB write; bits above the field width carry random junk
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val, input int width);
    logic [31:0] mask;
    logic [31:0] data;
    mask = (32'd1 << width) - 32'd1;
    data = ($urandom & ~mask) | (val & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic nst, input logic [15:0] g, input logic [15:0] a,
                                input logic [15:0] od, input logic [15:0] gn,
                                input logic [15:0] idl);
    write_reg(RG_NESTED, {31'd0, nst}, 1);
    write_reg(RG_OGAIN, {16'd0, g}, GainW);
    write_reg(RG_DGAIN, {16'd0, a}, GainW);
    write_reg(RG_ODLY, {16'd0, od}, OdlyW);
    write_reg(RG_IGAIN, {16'd0, gn}, GainW);
    write_reg(RG_IDLY, {16'd0, idl}, IdlyW);
  endtask

  initial begin
    logic signed [23:0] corner_vals [9];
    logic signed [23:0] rail_vals [6];
    corner_vals = '{24'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
                    24'sd1, -24'sd1, 24'sh7FFFFF, 24'sd0};
    rail_vals   = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                    24'sh800000, 24'sh800000, 24'sh800000};

    @(posedge rst_ni);
    @(negedge clk_i);

    // Reset settings: plain mode, half gain, no damping, unit delay
    foreach (corner_vals[i]) push_sample(corner_vals[i]);

    // Nested, both gains at -1.0, full damping, zero delays
    settle();
    apply_settings(1'b1, 16'h8000, 16'hFFFF, 16'd0, 16'h8000, 16'd0);
    foreach (rail_vals[i]) if (i < 5) push_sample(corner_vals[i]);

    // Nested, gains near +1.0, no damping, unit delays: drives feedback into saturation
    settle();
    apply_settings(1'b1, 16'h7FFF, 16'd0, 16'd1, 16'h7FFF, 16'd1);
    foreach (rail_vals[i]) push_sample(rail_vals[i]);

    // Longest delays, plain mode, half damping
    settle();
    apply_settings(1'b0, 16'hC000, 16'h8000, 16'd4095, 16'h4000, 16'd1023);
    repeat (3) push_sample(pick_sample());

    // Random settings, alternating plain and nested
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      steady = (ph % 4 == 2);
      apply_settings(1'(ph % 2), rand_gain(), rand_gain(), rand_delay(16'd4095),
                     rand_gain(), rand_delay(16'd1023));
      if ($urandom_range(0, 2) == 0) write_reg(UnmappedIdx, $urandom, 32);
      repeat (56) push_sample(pick_sample());
    end

    steady = 1'b0;
    settle();
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
